// ----- design/i2cmts_pkg.sv -----
// Package for the i2c master transfer sequencer: transaction structs,
// operation, command, error and mode codes, bus status codes.
// No dependencies.
package i2cmts_pkg;

  // default transmit buffer depth
  localparam int unsigned SendDepthDefault = 16;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_EVENT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_RELEASE = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_BUSY = 2'd1,
    ERR_FULL = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TX   = 2'd1,
    MODE_RX   = 2'd2
  } mode_e;

  // bus status codes after masking the low three bits
  localparam logic [7:0] StatusMask     = 8'hF8;
  localparam logic [7:0] StStart        = 8'h08;
  localparam logic [7:0] StRepStart     = 8'h10;
  localparam logic [7:0] StAddrWAck     = 8'h18;
  localparam logic [7:0] StAddrWNack    = 8'h20;
  localparam logic [7:0] StDataWAck     = 8'h28;
  localparam logic [7:0] StDataWNack    = 8'h30;
  localparam logic [7:0] StArbLost      = 8'h38;
  localparam logic [7:0] StAddrRAck     = 8'h40;
  localparam logic [7:0] StAddrRNack    = 8'h48;
  localparam logic [7:0] StDataRAck     = 8'h50;
  localparam logic [7:0] StDataRNack    = 8'h58;

  // address byte direction handling
  localparam logic [7:0] AddrWriteMask  = 8'hFE;
  localparam logic [7:0] AddrReadBit    = 8'h01;
  localparam logic [7:0] RecvCountMax   = 8'hFF;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] dev_addr;
    logic [7:0] read_length;
    logic [7:0] tx_byte;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] byte_out;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       busy_res;
    logic [1:0] error;
  } out_item_t;

endpackage

// ----- design/i2c_master_transfer_sequencer.sv -----
// Top level of the i2c master transfer sequencer: input register, decode,
// transfer state, transmit buffer and result register.
// Depends on i2cmts_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------
//   in      | into      | in_valid_i / in_stall_o  | in_item_i (in_item_t)
//   out     | out of    | out_valid_o / out_stall_i| out_item_o (out_item_t)
//
// One transaction per cycle sustained while the output is not stalled; each
// transaction passes the input register, then the result register, before its result is offered.
// The transmit buffer read port is registered and prefetches the next byte.
// Reset clears the transfer state and both pipeline valids; buffer contents
// stay undefined until pushed.
// A stall on the output holds the result and backs up into the input stage.
module i2c_master_transfer_sequencer #(
  parameter int unsigned SEND_DEPTH = i2cmts_pkg::SendDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  i2cmts_pkg::in_item_t  in_item_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output i2cmts_pkg::out_item_t out_item_o,
  input  logic                  out_stall_i
);
  import i2cmts_pkg::*;

  localparam int unsigned CntW = $clog2(SEND_DEPTH + 1);
  localparam int unsigned IdxW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
  localparam logic [CntW-1:0] DepthVal = CntW'(SEND_DEPTH);

  // pipeline registers
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      advance;

  // transfer state
  mode_e           mode_q, mode_d;
  logic [7:0]      target_q, target_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [7:0]      rcount_q, rcount_d;
  logic [7:0]      rtotal_q, rtotal_d;

  // transmit buffer with registered prefetch of the byte at pos
  logic [7:0] store_q [SEND_DEPTH];
  logic [7:0] head_q;

  // decode results
  logic [7:0] status;
  logic       busy;
  logic       do_push, do_begin_tx, do_begin_rx, do_finish, do_send_data, do_bump;
  logic [7:0] rcount_bumped;
  cmd_e       cmd;
  err_e       err;
  logic [7:0] bout;
  logic       rxv;
  logic [7:0] rxd;

  // pipeline handshake
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status = in_q.bus_status & StatusMask;
  assign busy   = (mode_q != MODE_IDLE);

  // saturating receive count used for the ack decision
  assign rcount_bumped = (do_bump && (rcount_q != RecvCountMax)) ?
                         (rcount_q + 8'd1) : rcount_q;

  // decode one transaction against the current state
  always_comb begin
    cmd          = CMD_NONE;
    err          = ERR_NONE;
    bout         = 8'd0;
    rxv          = 1'b0;
    rxd          = 8'd0;
    do_push      = 1'b0;
    do_begin_tx  = 1'b0;
    do_begin_rx  = 1'b0;
    do_finish    = 1'b0;
    do_send_data = 1'b0;
    do_bump      = 1'b0;
    case (op_e'(in_q.operation))
      OP_PUSH: begin
        if (busy) begin
          err = ERR_BUSY;
        end else if (fill_q >= DepthVal) begin
          err = ERR_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
      OP_WRITE: begin
        if (busy) begin
          err = ERR_BUSY;
        end else begin
          do_begin_tx = 1'b1;
          cmd         = CMD_START;
        end
      end
      OP_READ: begin
        if (busy) begin
          err = ERR_BUSY;
        end else begin
          do_begin_rx = 1'b1;
          cmd         = CMD_START;
        end
      end
      OP_EVENT: begin
        if (busy) begin
          case (status)
            StStart, StRepStart: begin
              cmd  = CMD_SEND;
              bout = target_q;
            end
            StAddrWAck, StDataWAck: begin
              if ((pos_q < fill_q) && (pos_q < DepthVal)) begin
                cmd          = CMD_SEND;
                bout         = head_q;
                do_send_data = 1'b1;
              end else begin
                cmd       = CMD_STOP;
                do_finish = 1'b1;
              end
            end
            StDataRNack: begin
              rxv       = 1'b1;
              rxd       = in_q.rx_byte;
              do_bump   = 1'b1;
              cmd       = CMD_STOP;
              do_finish = 1'b1;
            end
            StAddrRNack, StAddrWNack, StDataWNack: begin
              cmd       = CMD_STOP;
              do_finish = 1'b1;
            end
            StArbLost: begin
              cmd       = CMD_RELEASE;
              do_finish = 1'b1;
            end
            StDataRAck, StAddrRAck: begin
              if (status == StDataRAck) begin
                rxv     = 1'b1;
                rxd     = in_q.rx_byte;
                do_bump = 1'b1;
              end
              cmd = (({1'b0, rcount_bumped} + 9'd1) < {1'b0, rtotal_q}) ?
                    CMD_RX_ACK : CMD_RX_NACK;
            end
            default: begin
              cmd = CMD_NONE;
            end
          endcase
        end
      end
      default: begin
        cmd = CMD_NONE;
      end
    endcase
  end

  // next mode
  always_comb begin
    mode_d = mode_q;
    if (advance) begin
      if (do_begin_tx) begin
        mode_d = MODE_TX;
      end else if (do_begin_rx) begin
        mode_d = MODE_RX;
      end else if (do_finish) begin
        mode_d = MODE_IDLE;
      end
    end
  end

  // next values of the remaining transfer state
  always_comb begin
    target_d = target_q;
    fill_d   = fill_q;
    pos_d    = pos_q;
    rcount_d = rcount_q;
    rtotal_d = rtotal_q;
    if (advance) begin
      if (do_push) begin
        fill_d = fill_q + CntW'(1);
      end
      if (do_begin_tx) begin
        target_d = in_q.dev_addr & AddrWriteMask;
        pos_d    = '0;
      end
      if (do_begin_rx) begin
        target_d = in_q.dev_addr | AddrReadBit;
        rcount_d = 8'd0;
        rtotal_d = in_q.read_length;
      end
      if (do_send_data) begin
        pos_d = pos_q + CntW'(1);
      end
      if (do_bump) begin
        rcount_d = rcount_bumped;
      end
      // end of a write transfer empties the buffer
      if (do_finish && (mode_q == MODE_TX)) begin
        fill_d = '0;
        pos_d  = '0;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.command  <= cmd;
      out_q.byte_out <= bout;
      out_q.rx_valid <= rxv;
      out_q.rx_data  <= rxd;
      out_q.busy_res <= (mode_d != MODE_IDLE);
      out_q.error    <= err;
    end
  end

  // transfer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      target_q <= 8'd0;
      fill_q   <= '0;
      pos_q    <= '0;
      rcount_q <= 8'd0;
      rtotal_q <= 8'd0;
    end else begin
      mode_q   <= mode_d;
      target_q <= target_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      rcount_q <= rcount_d;
      rtotal_q <= rtotal_d;
    end
  end

  // buffer write at fill, registered read at the next position with bypass
  always_ff @(posedge clk_i) begin
    if (advance && do_push) begin
      store_q[fill_q[IdxW-1:0]] <= in_q.tx_byte;
    end
    if (advance && do_push && (fill_q == pos_d)) begin
      head_q <= in_q.tx_byte;
    end else begin
      head_q <= store_q[pos_d[IdxW-1:0]];
    end
  end

endmodule

// ----- verif/i2c_master_transfer_sequencer_tb.sv -----
// Testbench for the i2c master transfer sequencer: directed and random
// transfers checked against a cycle-free model of the transfer state.
// Depends on i2cmts_pkg and i2c_master_transfer_sequencer.
module i2c_master_transfer_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cmts_pkg::*;

  localparam int unsigned Depth = SendDepthDefault;
  localparam int TotalItems = 750;
  // a status value that carries no known code once masked
  localparam logic [7:0] StNoCode = 8'h00;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  in_item_t  in_item_i;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;
  logic      out_stall_i;

  // transfer model state
  mode_e      xfer_mode;
  logic [7:0] addr_byte;
  logic [7:0] tx_store [Depth];
  int         tx_fill;
  int         tx_pos;
  int         rx_count;
  int         rx_total;
  cmd_e       last_cmd;

  out_item_t pending_results[$];
  int        mismatches;
  int        items_sent;
  bit        calm;

  i2c_master_transfer_sequencer #(
    .SEND_DEPTH(Depth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // end of a transfer; a write transfer drops its buffer
  function automatic void close_transfer();
    if (xfer_mode == MODE_TX) begin
      tx_fill = 0;
      tx_pos = 0;
    end
    xfer_mode = MODE_IDLE;
  endfunction

  // expected bus command and flags for one transaction, updates model state
  function automatic out_item_t bus_result(in_item_t it);
    out_item_t  r;
    logic [7:0] code;
    r = '0;
    code = it.bus_status & StatusMask;
    case (op_e'(it.operation))
      OP_PUSH: begin
        if (xfer_mode != MODE_IDLE) begin
          r.error = ERR_BUSY;
        end else if (tx_fill >= Depth) begin
          r.error = ERR_FULL;
        end else begin
          tx_store[tx_fill] = it.tx_byte;
          tx_fill++;
        end
      end
      OP_WRITE, OP_READ: begin
        if (xfer_mode != MODE_IDLE) begin
          r.error = ERR_BUSY;
        end else if (op_e'(it.operation) == OP_WRITE) begin
          xfer_mode = MODE_TX;
          addr_byte = it.dev_addr & AddrWriteMask;
          tx_pos = 0;
          r.command = CMD_START;
        end else begin
          xfer_mode = MODE_RX;
          addr_byte = it.dev_addr | AddrReadBit;
          rx_count = 0;
          rx_total = it.read_length;
          r.command = CMD_START;
        end
      end
      default: begin
        if (xfer_mode != MODE_IDLE) begin
          case (code)
            StStart, StRepStart: begin
              r.command = CMD_SEND;
              r.byte_out = addr_byte;
            end
            StAddrWAck, StDataWAck: begin
              if (tx_pos < tx_fill) begin
                r.command = CMD_SEND;
                r.byte_out = tx_store[tx_pos];
                tx_pos++;
              end else begin
                r.command = CMD_STOP;
                close_transfer();
              end
            end
            StDataRNack: begin
              r.rx_valid = 1'b1;
              r.rx_data = it.rx_byte;
              if (rx_count < RecvCountMax) rx_count++;
              r.command = CMD_STOP;
              close_transfer();
            end
            StAddrRNack, StAddrWNack, StDataWNack: begin
              r.command = CMD_STOP;
              close_transfer();
            end
            StArbLost: begin
              r.command = CMD_RELEASE;
              close_transfer();
            end
            StDataRAck, StAddrRAck: begin
              if (code == StDataRAck) begin
                r.rx_valid = 1'b1;
                r.rx_data = it.rx_byte;
                if (rx_count < RecvCountMax) rx_count++;
              end
              r.command = (rx_count + 1 < rx_total) ? CMD_RX_ACK : CMD_RX_NACK;
            end
            default: ;
          endcase
        end
      end
    endcase
    r.busy_res = (xfer_mode != MODE_IDLE);
    if (cmd_e'(r.command) != CMD_NONE) last_cmd = cmd_e'(r.command);
    return r;
  endfunction

  // one input transaction, with a random lead-in gap
  task automatic send_item(input in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(bus_result(it));
    items_sent++;
  endtask

  task automatic send_op(input op_e op, input logic [7:0] addr, input logic [7:0] rlen,
                         input logic [7:0] txb, input logic [7:0] st,
                         input logic [7:0] rxb);
    in_item_t it;
    it.operation = op;
    it.dev_addr = addr;
    it.read_length = rlen;
    it.tx_byte = txb;
    it.bus_status = st;
    it.rx_byte = rxb;
    send_item(it);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it.operation = 2'($urandom_range(0, 3));
    it.dev_addr = 8'($urandom_range(0, 255));
    it.read_length = 8'($urandom_range(0, 255));
    it.tx_byte = 8'($urandom_range(0, 255));
    it.bus_status = 8'($urandom_range(0, 255));
    it.rx_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // plausible next bus status after the last command issued
  function automatic logic [7:0] next_status();
    int r;
    r = $urandom_range(0, 99);
    case (last_cmd)
      CMD_START: return (r < 50) ? StStart : StRepStart;
      CMD_SEND: begin
        if (xfer_mode == MODE_TX) begin
          if (r < 40) return StAddrWAck;
          if (r < 80) return StDataWAck;
          if (r < 85) return StAddrWNack;
          if (r < 90) return StDataWNack;
          return StArbLost;
        end
        return (r < 85) ? StAddrRAck : StAddrRNack;
      end
      CMD_RX_ACK: begin
        if (r < 90) return StDataRAck;
        if (r < 95) return StDataRNack;
        return StArbLost;
      end
      CMD_RX_NACK: return (r < 95) ? StDataRNack : StDataRAck;
      default: return (xfer_mode == MODE_TX) ? StDataWAck : StDataRAck;
    endcase
  endfunction

  // bus events until the transfer ends, with some rejected requests and junk
  task automatic drive_transfer();
    in_item_t it;
    int       r;
    while (xfer_mode != MODE_IDLE) begin
      it = random_item();
      r = $urandom_range(0, 99);
      if (r < 4) begin
        it.operation = 2'($urandom_range(0, 2));
      end else begin
        it.operation = OP_EVENT;
        if (r >= 8) it.bus_status = next_status() | 8'($urandom_range(0, 7));
      end
      send_item(it);
    end
  endtask

  // extremes, every operation and each corner of the transfer flow
  task automatic test_directed();
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StStart, 8'h00);
    send_op(OP_PUSH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_op(OP_PUSH, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00);
    send_op(OP_WRITE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_op(OP_PUSH, 8'h00, 8'h00, 8'h5A, 8'h00, 8'h00);
    send_op(OP_READ, 8'h42, 8'h03, 8'h00, 8'h00, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StStart | 8'h07, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StAddrWAck, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StNoCode | 8'h07, 8'hFF);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StDataWAck | 8'h07, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StDataWAck, 8'h00);
    // zero-length read: nack right after the address
    send_op(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StRepStart, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StAddrRAck, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StDataRNack, 8'hFF);
    // single-byte read, then lost arbitration
    send_op(OP_READ, 8'hA4, 8'h01, 8'h00, 8'h00, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StStart, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StAddrRAck, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StDataRAck, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StArbLost, 8'h00);
    // address nack on write, data nack, address nack on read
    send_op(OP_PUSH, 8'h00, 8'h00, 8'h3C, 8'h00, 8'h00);
    send_op(OP_WRITE, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StAddrWNack, 8'h00);
    send_op(OP_WRITE, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StDataWNack, 8'h00);
    send_op(OP_READ, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StAddrRNack, 8'h00);
  endtask

  // longest read with extra data events so the receive count saturates
  task automatic test_receive_saturation();
    send_op(OP_READ, 8'($urandom_range(0, 255)), 8'hFF, 8'h00, 8'h00, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StStart, 8'h00);
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StAddrRAck, 8'h00);
    repeat (258) begin
      send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StDataRAck | 8'($urandom_range(0, 7)),
              8'($urandom_range(0, 255)));
    end
    send_op(OP_EVENT, 8'h00, 8'h00, 8'h00, StDataRNack, 8'($urandom_range(0, 255)));
  endtask

  // random write and read transfers mixed with unstructured transactions
  task automatic test_random_transfers();
    in_item_t it;
    int       sel;
    int       n;
    while (items_sent < TotalItems) begin
      calm = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 5);
        repeat (n) begin
          it = random_item();
          it.operation = OP_PUSH;
          send_item(it);
        end
        it = random_item();
        it.operation = OP_WRITE;
        send_item(it);
        drive_transfer();
      end else if (sel < 80) begin
        it = random_item();
        it.operation = OP_READ;
        if ($urandom_range(0, 19) != 0) it.read_length = 8'($urandom_range(0, 6));
        send_item(it);
        drive_transfer();
      end else begin
        repeat ($urandom_range(1, 4)) send_item(random_item());
        drive_transfer();
      end
    end
    calm = 1'b0;
  endtask

  // output stall, drawn per result
  initial begin : stall_gen
    int k;
    wait (rst_ni);
    forever begin
      k = calm ? 0 : $urandom_range(0, 4);
      if (k > 0) begin
        out_stall_i <= 1'b1;
        repeat (k) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!(out_valid_o && !out_stall_i)) @(posedge clk_i);
    end
  end

  // compare each result transaction with the oldest expected one
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result cmd=%0d byte=%h rxv=%0b rxd=%h busy=%0b err=%0d",
                 $realtime, out_item_o.command, out_item_o.byte_out, out_item_o.rx_valid,
                 out_item_o.rx_data, out_item_o.busy_res, out_item_o.error);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.command !== want.command || out_item_o.byte_out !== want.byte_out ||
            out_item_o.rx_valid !== want.rx_valid || out_item_o.rx_data !== want.rx_data ||
            out_item_o.busy_res !== want.busy_res || out_item_o.error !== want.error) begin
          $display("%0t: expected cmd=%0d byte=%h rxv=%0b rxd=%h busy=%0b err=%0d",
                   $realtime, want.command, want.byte_out, want.rx_valid, want.rx_data,
                   want.busy_res, want.error);
          $display("%0t: actual   cmd=%0d byte=%h rxv=%0b rxd=%h busy=%0b err=%0d",
                   $realtime, out_item_o.command, out_item_o.byte_out, out_item_o.rx_valid,
                   out_item_o.rx_data, out_item_o.busy_res, out_item_o.error);
          mismatches++;
        end
      end
    end
  end

  // run limit
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // reset, tests, drain
  initial begin
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    out_stall_i <= 1'b0;
    rst_ni <= 1'b0;
    xfer_mode = MODE_IDLE;
    addr_byte = '0;
    tx_fill = 0;
    tx_pos = 0;
    rx_count = 0;
    rx_total = 0;
    last_cmd = CMD_NONE;
    mismatches = 0;
    items_sent = 0;
    calm = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_receive_saturation();
    test_random_transfers();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
